[rtl/orq_pkg.sv]
// Shared types and codes for the ordered run queue.
// No dependencies.
package orq_pkg;

   localparam int ID_W    = 6;
   localparam int ID_SPACE = 64;
   localparam int COUNT_W = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_DUP   = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic            append_go;
      logic            remove_go;
      logic [ID_W-1:0] id;
   } cell_ctl_type;

endpackage

[rtl/orq_cell.sv]
// One queue slot: holds an id and a valid bit, moves a removal hole rightward.
// Depends on orq_pkg.
module orq_cell
   import orq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cell_ctl_type    ctl,
   input  logic            left_valid,
   input  logic            left_hole,
   input  logic            right_valid,
   input  logic [ID_W-1:0] right_id,
   output logic            valid,
   output logic [ID_W-1:0] id,
   output logic            hole_active
);

   logic            valid_ff, valid_in;
   logic            hole_ff, hole_in;
   logic [ID_W-1:0] id_ff, id_in;

   assign valid       = valid_ff;
   assign id          = id_ff;
   assign hole_active = hole_ff & valid_ff;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      hole_in  = left_hole;
      if (ctl.remove_go) begin
         hole_in = valid_ff && (id_ff == ctl.id);
      end else if (hole_active) begin
         valid_in = right_valid;
         id_in    = right_id;
      end else if (ctl.append_go && !valid_ff && left_valid) begin
         valid_in = 1'b1;
         id_in    = ctl.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hole_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hole_ff  <= hole_in;
      end
      id_ff <= id_in;
   end

endmodule

[rtl/ordered_run_queue_with_removal.sv]
// Ordered run queue of process ids with removal from any position.
// Top level: controller, membership flags and a row of orq_cell slots; uses orq_pkg.
//
// Request channel (req_): tuser carries the opcode (append or remove), tdata the id.
// Response channel (rsp_): one response per request with status, presence,
// count after the step, non-empty flag and head id.
// The queue lives in a row of cells, front at cell 0. An append loads the
// first empty cell; a removal marks the matching cell and the hole then
// moves one cell to the right per cycle as each cell pulls from its right
// neighbor, closing the gap while keeping order.
// The response is registered and appears in the cycle after the request is taken.
// An append or a no-op request leaves the row settled. A removal keeps the
// row busy while its hole walks down the cell row from the removed position
// to the last occupied cell; the row holds min(MAX_ENTRIES, 64) cells
// (64 by default). A removal's response can wait in its register while that
// removal's compaction runs; a new request is taken only once the row
// is settled and the response register is free or being drained.
// Reset empties the queue at once (cell valid bits and membership flags clear).
// A stalled receiver holds the response and blocks further requests.
module ordered_run_queue_with_removal
   import orq_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] opcode
   input  logic [7:0]  req_tdata,   // [5:0] proc_id, [7:6] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [2] was_present, [9:3] entry_count, [10] not_empty,
   // [16:11] head_id, [23:17] zero
   output logic [23:0] rsp_tdata
);

   localparam int NUM_CELLS = (MAX_ENTRIES < ID_SPACE) ? MAX_ENTRIES : ID_SPACE;

   logic [NUM_CELLS-1:0]           valid_vec;
   logic [NUM_CELLS-1:0]           hole_vec;
   logic [NUM_CELLS-1:0][ID_W-1:0] id_vec;

   logic [ID_SPACE-1:0] member_ff, member_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff;
   logic [23:0]         rsp_data_ff;

   logic               compacting, accept, present, is_remove;
   logic [ID_W-1:0]    req_id;
   status_type         status;
   logic [COUNT_W-1:0] new_count;
   logic [ID_W-1:0]    new_head;
   cell_ctl_type       ctl;

   assign compacting = |hole_vec;
   assign req_tready = !compacting && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign req_id     = req_tdata[ID_W-1:0];
   assign is_remove  = (opcode_type'(req_tuser[0]) == OP_REMOVE);
   assign present    = member_ff[req_id];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status    = ST_OK;
      new_count = count_ff;
      member_in = member_ff;
      ctl.append_go = 1'b0;
      ctl.remove_go = 1'b0;
      ctl.id        = req_id;
      if (!is_remove) begin
         if (present) begin
            status = ST_DUP;
         end else if (count_ff >= COUNT_W'(NUM_CELLS)) begin
            status = ST_FULL;
         end else begin
            ctl.append_go     = accept;
            new_count         = count_ff + 1'b1;
            member_in[req_id] = 1'b1;
         end
      end else begin
         if (count_ff == '0) begin
            status = ST_EMPTY;
         end else if (present) begin
            ctl.remove_go     = accept;
            new_count         = count_ff - 1'b1;
            member_in[req_id] = 1'b0;
         end
      end
      if (new_count == '0) begin
         new_head = '0;
      end else if (!is_remove && count_ff == '0) begin
         new_head = req_id;
      end else if (is_remove && present && id_vec[0] == req_id) begin
         new_head = id_vec[1];
      end else begin
         new_head = id_vec[0];
      end
      count_in = accept ? new_count : count_ff;
   end

   genvar g;
   generate
      for (g = 0; g < NUM_CELLS; g++) begin : g_cell
         logic            lv, lh, rv;
         logic [ID_W-1:0] rid;
         if (g == 0) begin : g_first
            assign lv = 1'b1;
            assign lh = 1'b0;
         end else begin : g_mid
            assign lv = valid_vec[g-1];
            assign lh = hole_vec[g-1];
         end
         if (g == NUM_CELLS-1) begin : g_last
            assign rv  = 1'b0;
            assign rid = '0;
         end else begin : g_inner
            assign rv  = valid_vec[g+1];
            assign rid = id_vec[g+1];
         end
         orq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .left_valid  (lv),
            .left_hole   (lh),
            .right_valid (rv),
            .right_id    (rid),
            .valid       (valid_vec[g]),
            .id          (id_vec[g]),
            .hole_active (hole_vec[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         member_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            member_ff    <= member_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_data_ff <= {7'd0, new_head, (new_count != '0), new_count, present, status};
      end
   end

`ifndef SYNTHESIS
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      compacting |-> !req_tready)
      else $error("request taken during compaction");
   a_count_flags: assert property (@(posedge clock) disable iff (reset)
      COUNT_W'($countones(member_ff)) == count_ff)
      else $error("count disagrees with membership flags");
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("response missing after request");
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      !compacting |-> (valid_vec[0] == (count_ff != '0)))
      else $error("front cell disagrees with count");
`endif

endmodule
